// ----- rtl/zdi_pkg.sv -----
// zdi_pkg: types and constants shared by the zero-velocity-update double integrator.
// Used by zdi_ctrl, zdi_datapath and zupt_double_integrator.
`default_nettype none

package zdi_pkg;

    localparam int DT_W   = 16;   // time step, 2^-20 s
    localparam int ACC_W  = 24;   // acceleration, Q8.16 m/s^2
    localparam int DIST_W = 32;   // velocity, position and latch, Q16.16
    localparam int FRAC_SHIFT = 20;

    // tuser bit positions on the input channel
    localparam int USER_MOVING = 0;
    localparam int USER_CLEAR  = 1;
    localparam int USER_W      = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VEL,
        ST_POS
    } zdi_state_t;

    typedef struct packed {
        logic load;       // capture the accepted item
        logic vel_step;   // edge actions, latch clear, velocity update
        logic pos_step;   // position update and result load
    } zdi_cmd_t;

    // a plus b, clipped to the signed 32-bit range
    function automatic logic signed [DIST_W-1:0] sat_add(
        input logic signed [DIST_W-1:0] a,
        input logic signed [DIST_W:0]   b
    );
        logic signed [DIST_W+1:0] s;
        s = {{2{a[DIST_W-1]}}, a} + {b[DIST_W], b};
        if (s[DIST_W+1:DIST_W-1] == 3'b000 || s[DIST_W+1:DIST_W-1] == 3'b111) begin
            sat_add = s[DIST_W-1:0];
        end else if (s[DIST_W+1]) begin
            sat_add = {1'b1, {(DIST_W-1){1'b0}}};
        end else begin
            sat_add = {1'b0, {(DIST_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/zdi_ctrl.sv -----
// zdi_ctrl: sequencer for the integrator; handshakes and datapath commands.
// Depends on zdi_pkg for the state type and the command struct.
`default_nettype none

module zdi_ctrl
    import zdi_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output zdi_cmd_t  cmd
);

    zdi_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_VEL;
                end
            end
            ST_VEL: begin
                state_next = ST_POS;
            end
            ST_POS: begin
                // finish only once the result register can take the item
                if (out_free) begin
                    state_next = s_tvalid ? ST_VEL : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.vel_step = 1'b0;
        cmd.pos_step = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_VEL: begin
                cmd.vel_step = 1'b1;
            end
            ST_POS: begin
                cmd.pos_step = out_free;
                s_tready     = out_free;
                cmd.load     = out_free && s_tvalid;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.pos_step) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/zdi_datapath.sv -----
// zdi_datapath: per-axis velocity, position and latch lanes with the result register.
// Depends on zdi_pkg; driven by the commands of zdi_ctrl.
`default_nettype none

module zdi_datapath
    import zdi_pkg::*;
#(
    parameter int AXES = 3
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire zdi_cmd_t                  cmd,
    input  wire logic [DT_W+ACC_W*AXES-1:0] in_data,
    input  wire logic [USER_W-1:0]          in_user,
    output logic [DIST_W*AXES-1:0]          out_data
);

    localparam int VPROD_W = ACC_W + DT_W + 1;
    localparam int PPROD_W = DIST_W + DT_W + 1;

    logic [DT_W-1:0] dt_reg;
    logic            moving_reg;
    logic            clear_reg;
    logic            prev_moving_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dt_reg     <= in_data[DT_W-1:0];
            moving_reg <= in_user[USER_MOVING];
            clear_reg  <= in_user[USER_CLEAR];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_moving_reg <= 1'b0;
        end else if (cmd.vel_step) begin
            prev_moving_reg <= moving_reg;
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        logic signed [ACC_W-1:0]   acc_reg;
        logic signed [DIST_W-1:0]  vel_reg;
        logic signed [DIST_W-1:0]  pos_reg;
        logic signed [DIST_W-1:0]  latch_reg;
        logic        [DIST_W-1:0]  dist_reg;
        logic signed [VPROD_W-1:0] vprod;
        logic signed [PPROD_W-1:0] pprod;
        logic signed [DIST_W:0]    vinc;
        logic signed [DIST_W:0]    pinc;
        logic signed [DIST_W-1:0]  vel_base;
        logic signed [DIST_W-1:0]  vel_sum;
        logic signed [DIST_W-1:0]  pos_sum;

        // the products' high bits are the floor shift by FRAC_SHIFT
        assign vprod    = $signed(acc_reg) * $signed({1'b0, dt_reg});
        assign pprod    = $signed(vel_reg) * $signed({1'b0, dt_reg});
        assign vinc     = {{(DIST_W+1-(VPROD_W-FRAC_SHIFT)){vprod[VPROD_W-1]}},
                           vprod[VPROD_W-1:FRAC_SHIFT]};
        assign pinc     = {{(DIST_W+1-(PPROD_W-FRAC_SHIFT)){pprod[PPROD_W-1]}},
                           pprod[PPROD_W-1:FRAC_SHIFT]};
        // restart from rest on the first moving item
        assign vel_base = prev_moving_reg ? vel_reg : '0;
        assign vel_sum  = sat_add(vel_base, vinc);
        assign pos_sum  = sat_add(pos_reg, pinc);

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                acc_reg <= in_data[DT_W+ACC_W*g +: ACC_W];
            end
            if (cmd.pos_step) begin
                dist_reg <= moving_reg ? pos_sum : latch_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vel_reg   <= '0;
                pos_reg   <= '0;
                latch_reg <= '0;
            end else begin
                if (cmd.vel_step) begin
                    if (moving_reg) begin
                        vel_reg <= vel_sum;
                        if (!prev_moving_reg) begin
                            pos_reg <= '0;
                        end
                    end else if (prev_moving_reg) begin
                        vel_reg <= '0;
                    end
                    // on the falling edge the copy wins over a clear
                    if (!moving_reg && prev_moving_reg) begin
                        latch_reg <= pos_reg;
                    end else if (clear_reg) begin
                        latch_reg <= '0;
                    end
                end
                if (cmd.pos_step && moving_reg) begin
                    pos_reg <= pos_sum;
                end
            end
        end

        assign out_data[DIST_W*g +: DIST_W] = dist_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/zupt_double_integrator.sv -----
// zupt_double_integrator: top level of the zero-velocity-update double integrator.
// Depends on zdi_pkg, zdi_ctrl and zdi_datapath.
//
//  channel  | direction | tdata (low bit up)                 | tuser
//  ---------+-----------+------------------------------------+----------------------
//  s_       | in        | dt, accel per axis (x, y, z, ...)  | moving, clear
//  m_       | out       | dist per axis (x, y, z, ...)       | none
//
// Each item passes through ST_VEL, for the acceleration multiply and velocity
// update, then ST_POS, for the velocity multiply and position update; the next
// item is taken in ST_POS, so a new item is accepted while the last one finishes.
// Reset clears velocity, position, latch and the moving history.
// A stalled result register holds ST_POS and the input side.
`default_nettype none

module zupt_double_integrator
    import zdi_pkg::*;
#(
    parameter int AXES = 3
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // dt [15:0], then accel_x, accel_y, accel_z, 24 bits each
    input  wire logic [DT_W+ACC_W*AXES-1:0] s_tdata,
    // moving [0], clear [1]
    input  wire logic [USER_W-1:0]          s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // dist_x [31:0], dist_y, dist_z, 32 bits each
    output logic [DIST_W*AXES-1:0]          m_tdata
);

    zdi_cmd_t cmd;

    zdi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    zdi_datapath #(
        .AXES (AXES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/sv/zupt_double_integrator_test.sv -----
// Self-checking bench for zupt_double_integrator: directed cases, one long saturating
// run and random moving/still sequences, checked against an in-bench integrator.
// Depends on zdi_pkg and the zupt_double_integrator RTL.
`default_nettype none

module zupt_double_integrator_test;
    import zdi_pkg::*;

    localparam int AXES           = 3;
    localparam int IN_W           = DT_W + ACC_W * AXES;
    localparam int OUT_W          = DIST_W * AXES;
    localparam int STALL_MAX      = 8;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 1180;
    localparam int SATURATE_ITEMS = 500;
    localparam int REPORT_MAX     = 10;
    localparam longint DIST_MAX   = 64'sd2147483647;
    localparam longint DIST_MIN   = -64'sd2147483648;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DT_W-1:0]  DT_MAX  = '1;

    // Tracks velocity, position and the latched distance per axis and queues
    // the distance that each accepted sample must produce.
    class distance_tracker;
        logic signed [DIST_W-1:0] vel[AXES];
        logic signed [DIST_W-1:0] pos[AXES];
        logic signed [DIST_W-1:0] latch[AXES];
        bit moved_last;
        logic [OUT_W-1:0] expected_dist[$];
        int mismatches;

        function new();
            foreach (vel[i]) begin
                vel[i]   = '0;
                pos[i]   = '0;
                latch[i] = '0;
            end
            moved_last = 1'b0;
            mismatches = 0;
        endfunction

        // floor the product to Q16.16, then add with clipping to 32 bits
        static function logic signed [DIST_W-1:0] integrate(
            input logic signed [DIST_W-1:0] acc,
            input longint prod
        );
            longint s;
            s = longint'(acc) + (prod >>> FRAC_SHIFT);
            if (s > DIST_MAX) begin
                s = DIST_MAX;
            end else if (s < DIST_MIN) begin
                s = DIST_MIN;
            end
            return s[DIST_W-1:0];
        endfunction

        function void note_sample(input logic [IN_W-1:0] data, input logic [USER_W-1:0] user);
            longint step;
            longint a;
            bit moving;
            logic [OUT_W-1:0] dist_word;
            step = longint'(data[DT_W-1:0]);
            moving = user[USER_MOVING];
            if (user[USER_CLEAR]) begin
                foreach (latch[i]) latch[i] = '0;
            end
            if (moving) begin
                if (!moved_last) begin
                    foreach (vel[i]) begin
                        vel[i] = '0;
                        pos[i] = '0;
                    end
                end
                for (int i = 0; i < AXES; i++) begin
                    a = longint'($signed(data[DT_W + ACC_W*i +: ACC_W]));
                    vel[i] = integrate(vel[i], a * step);
                    // position uses the velocity just updated
                    pos[i] = integrate(pos[i], longint'(vel[i]) * step);
                    dist_word[DIST_W*i +: DIST_W] = pos[i];
                end
            end else begin
                if (moved_last) begin
                    foreach (vel[i]) begin
                        vel[i]   = '0;
                        latch[i] = pos[i];
                    end
                end
                for (int i = 0; i < AXES; i++) dist_word[DIST_W*i +: DIST_W] = latch[i];
            end
            moved_last = moving;
            expected_dist.push_back(dist_word);
        endfunction

        function void check_distance(input logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) $display("unexpected result: %h", got);
                return;
            end
            want = expected_dist.pop_front();
            for (int i = 0; i < AXES; i++) begin
                if (got[DIST_W*i +: DIST_W] !== want[DIST_W*i +: DIST_W]) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("dist[%0d]: expected %0d, got %0d", i,
                                 $signed(want[DIST_W*i +: DIST_W]),
                                 $signed(got[DIST_W*i +: DIST_W]));
                    end
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;   // dt [15:0], accel_x, accel_y, accel_z
    logic [USER_W-1:0] s_tuser  = '0;   // moving [0], clear [1]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // dist_x [31:0], dist_y, dist_z

    distance_tracker tracker = new();
    bit no_idle = 1'b0;
    int items_sent = 0;
    int quiet = 0;

    zupt_double_integrator #(
        .AXES(AXES)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [ACC_W-1:0] draw_accel();
        case ($urandom_range(0, 5))
            0: return ACC_MAX;
            1: return ACC_MIN;
            2: return ACC_W'($urandom_range(0, 2000) - 1000);
            default: return ACC_W'($urandom);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] draw_dt();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DT_MAX;
            2: return DT_W'($urandom_range(0, 64));
            default: return DT_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(
        input logic [DT_W-1:0]       dt,
        input logic [ACC_W*AXES-1:0] accels,
        input bit                    moving,
        input bit                    clear
    );
        int gap;
        logic [USER_W-1:0] user;
        gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        user = '0;
        user[USER_MOVING] = moving;
        user[USER_CLEAR]  = clear;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {accels, dt};
        s_tuser  <= user;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.note_sample({accels, dt}, user);
        items_sent++;
    endtask

    task automatic send_random(input bit moving, input bit clear);
        send_sample(draw_dt(), {draw_accel(), draw_accel(), draw_accel()}, moving, clear);
    endtask

    // hold the input side until every queued distance has come out
    task automatic wait_drained();
        while (tracker.expected_dist.size() != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // result side: random stall before each item
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            tracker.check_distance(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int target;
        int run;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: edges, clears, extremes and rounding
        send_sample('0, '0, 1'b0, 1'b0);
        send_sample(DT_MAX, {ACC_W'(0), ACC_MIN, ACC_MAX}, 1'b1, 1'b0);
        send_sample(DT_MAX, {ACC_W'(0), ACC_MIN, ACC_MAX}, 1'b1, 1'b0);
        send_sample('0, {ACC_MAX, ACC_MAX, ACC_MAX}, 1'b1, 1'b0);
        send_sample(DT_MAX, {ACC_MIN, ACC_MAX, ACC_MIN}, 1'b1, 1'b1);
        send_sample(DT_MAX, {ACC_MAX, ACC_MAX, ACC_MAX}, 1'b0, 1'b0);
        send_sample(DT_MAX, {ACC_MAX, ACC_MAX, ACC_MAX}, 1'b0, 1'b0);
        send_sample('0, '0, 1'b0, 1'b1);
        send_sample(DT_W'(1), {ACC_W'(-1), ACC_W'(1), ACC_W'(-1)}, 1'b1, 1'b0);
        send_sample(DT_W'(1), {ACC_W'(1), ACC_W'(-1), ACC_W'(1)}, 1'b1, 1'b0);
        send_sample(DT_W'(16'h5555), {24'h555555, 24'haaaaaa, 24'h555555}, 1'b1, 1'b0);
        send_sample(DT_W'(16'haaaa), {24'haaaaaa, 24'h555555, 24'haaaaaa}, 1'b1, 1'b0);
        send_sample(DT_MAX, {ACC_MIN, ACC_MIN, ACC_MIN}, 1'b1, 1'b0);
        send_sample('0, '0, 1'b0, 1'b1);
        send_sample('0, '0, 1'b0, 1'b0);
        send_sample(DT_MAX, {ACC_MAX, ACC_MIN, ACC_MAX}, 1'b1, 1'b1);
        send_sample(DT_MAX, {ACC_MAX, ACC_MIN, ACC_MAX}, 1'b1, 1'b0);
        send_sample(DT_MAX, {ACC_MIN, ACC_MAX, ACC_MIN}, 1'b0, 1'b1);
        send_sample(DT_W'(1000), {ACC_MAX, ACC_MAX, ACC_MAX}, 1'b0, 1'b0);
        wait_drained();

        // drive position into both limits and hold it there
        for (int k = 0; k < SATURATE_ITEMS; k++) begin
            if (k % 100 == 0) no_idle = ($urandom_range(0, 1) == 1);
            send_sample(DT_MAX, {draw_accel(), ACC_MIN, ACC_MAX}, 1'b1, k % 250 == 249);
        end
        send_sample(draw_dt(), '0, 1'b0, 1'b0);
        send_sample(draw_dt(), '0, 1'b0, 1'b0);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                // moving run followed by a still stretch
                run = $urandom_range(1, 40);
                repeat (run) send_random(1'b1, $urandom_range(0, 15) == 0);
                run = $urandom_range(1, 6);
                repeat (run) send_random(1'b0, $urandom_range(0, 5) == 0);
            end else begin
                run = $urandom_range(1, 10);
                repeat (run) send_random($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.expected_dist.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/zdi_pkg.sv
rtl/zdi_ctrl.sv
rtl/zdi_datapath.sv
rtl/zupt_double_integrator.sv
tb/sv/zupt_double_integrator_test.sv
